[hdl/rnps_pkg.sv]
// ----------------------------------------------------------------------------
// Route nearest point search package
// Shared widths, mode codes and the per-point record.
// ----------------------------------------------------------------------------
package rnps_pkg;

  localparam int unsigned MaxPointsDefault = 1024;
  localparam int unsigned LatW   = 31;
  localparam int unsigned LonW   = 32;
  localparam int unsigned HdgW   = 9;
  localparam int unsigned StepW  = 17;
  localparam int unsigned StepsW = 7;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned DiffW  = 33;
  localparam int unsigned TolW   = StepW + StepsW;
  localparam int unsigned SqW    = 2 * TolW + 1;

  localparam logic [1:0] ModeClear  = 2'd0;
  localparam logic [1:0] ModeAppend = 2'd1;
  localparam logic [1:0] ModeQuery  = 2'd2;

  localparam logic CfgStep  = 1'b0;
  localparam logic CfgSteps = 1'b1;

  typedef struct packed {
    logic signed [LatW-1:0] lat;
    logic signed [LonW-1:0] lon;
    logic [HdgW-1:0]        hdg;
  } point_t;

endpackage

[hdl/rnps_cell.sv]
// ----------------------------------------------------------------------------
// Route nearest point search cell
// One stage of the scan chain: tests the candidate's squared distance
// against one tolerance round, then passes the candidate on.
// ----------------------------------------------------------------------------
module rnps_cell
  import rnps_pkg::*;
#(
  parameter int unsigned IW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  logic [IW-1:0]   idx_i,
  input  logic            ok_i,
  input  logic [SqW-1:0]  d2_i,
  input  logic [SqW-1:0]  t2_i,
  input  logic [StepsW-1:0] k_i,
  output logic            vld_o,
  output logic [IW-1:0]   idx_o,
  output logic            ok_o,
  output logic [StepsW-1:0] k_o
);

  logic vld_q, ok_q;
  logic [IW-1:0] idx_q;
  logic [StepsW-1:0] k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_i;
    ok_q  <= ok_i && (d2_i < t2_i);
    k_q   <= k_i;
  end

  assign vld_o = vld_q;
  assign idx_o = idx_q;
  assign ok_o  = ok_q;
  assign k_o   = k_q;

endmodule

[hdl/route_nearest_point_search.sv]
// ----------------------------------------------------------------------------
// Route nearest point search
// Point table with append, clear and a widening-tolerance nearest point query.
// ----------------------------------------------------------------------------
// A query scans the table from start_index once per tolerance round. Each round
// reads every entry from start_index up to count (none when start_index is at
// or past count), sees the end of the table and drains the distance pipeline
// and its cell. Rounds run one after the other and stop at the first round
// with a match, so a query costs up to tolerance_steps rounds (none when
// tolerance_steps is zero). The result then waits in S_DONE and is loaded into
// an output register once that register is free, and the input is ready again
// in that same cycle. Appends and clears are taken back to back while no query
// is in progress and give no result, even while a result waits. A new query
// may start while a result waits; it holds its own answer until the output
// register is free.
module route_nearest_point_search
  import rnps_pkg::*;
#(
  parameter int unsigned MaxPoints = MaxPointsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [StepW-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              mode_i,
  input  logic signed [LatW-1:0]  latitude_i,
  input  logic signed [LonW-1:0]  longitude_i,
  input  logic [HdgW-1:0]         heading_i,
  input  logic [IdxW-1:0]         start_index_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    found_o,
  output logic [IdxW-1:0]         point_index_o
);

  localparam int unsigned AW = $clog2(MaxPoints);
  localparam int unsigned CW = $clog2(MaxPoints + 1);
  localparam int unsigned IW = (AW > IdxW) ? AW : IdxW;
  localparam int unsigned RW = IW + 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_e;

  state_e state_q;
  point_t mem [MaxPoints];
  logic [CW-1:0] count_q;
  logic [StepW-1:0] step_q;
  logic [StepsW-1:0] steps_q;

  point_t qry_q;
  logic [IdxW-1:0] start_q;
  logic [RW-1:0] rd_q;
  logic [RW-1:0] cnt_ext;
  logic [StepsW-1:0] k_q;
  logic [TolW-1:0] tol_q, max_q;
  logic [SqW-1:0] t2_q;
  logic hit_q, found_q;
  logic [IdxW-1:0] pidx_q;
  logic [3:0] drain_q;

  // Output register, so a waiting result does not hold up appends and clears.
  logic out_valid_q, res_found_q;
  logic [IdxW-1:0] res_idx_q;
  logic res_load;

  // Stage 0: memory read.
  point_t rd_pt_q;
  logic s0_v_q;
  logic [IW-1:0] s0_i_q;
  // Stage 1: differences.
  logic s1_v_q, s1_ok_q;
  logic [IW-1:0] s1_i_q;
  logic [DiffW-1:0] dl_q, dn_q;
  // Stage 2: squares.
  logic s2_v_q, s2_ok_q;
  logic [IW-1:0] s2_i_q;
  logic [2*TolW-1:0] sl_q, sn_q;
  // Stage 3: sum.
  logic s3_v_q, s3_ok_q;
  logic [IW-1:0] s3_i_q;
  logic [SqW-1:0] d2_q;

  logic c_v, c_ok;
  logic [IW-1:0] c_i;
  logic [StepsW-1:0] c_k;

  logic signed [DiffW-1:0] dla, dna;
  logic [DiffW-1:0] dlabs, dnabs;

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign found_o       = res_found_q;
  assign point_index_o = res_idx_q;
  assign cnt_ext       = RW'(count_q);
  assign res_load      = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    dla = DiffW'(rd_pt_q.lat) - DiffW'(qry_q.lat);
    dna = DiffW'(rd_pt_q.lon) - DiffW'(qry_q.lon);
    dlabs = dla[DiffW-1] ? DiffW'(-dla) : DiffW'(dla);
    dnabs = dna[DiffW-1] ? DiffW'(-dna) : DiffW'(dna);
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o && mode_i == ModeAppend && count_q < CW'(MaxPoints)) begin
      mem[count_q[AW-1:0]] <= '{lat: latitude_i, lon: longitude_i, hdg: heading_i};
    end
    rd_pt_q <= mem[rd_q[AW-1:0]];
    s0_i_q  <= rd_q[IW-1:0];
    s1_i_q  <= s0_i_q;
    s1_ok_q <= (rd_pt_q.hdg == qry_q.hdg) && (dlabs < DiffW'(max_q))
               && (dnabs < DiffW'(max_q));
    dl_q    <= dlabs;
    dn_q    <= dnabs;
    s2_i_q  <= s1_i_q;
    s2_ok_q <= s1_ok_q;
    sl_q    <= dl_q[TolW-1:0] * dl_q[TolW-1:0];
    sn_q    <= dn_q[TolW-1:0] * dn_q[TolW-1:0];
    s3_i_q  <= s2_i_q;
    s3_ok_q <= s2_ok_q;
    d2_q    <= SqW'(sl_q) + SqW'(sn_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s0_v_q <= (state_q == S_SCAN) && (rd_q < cnt_ext);
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  rnps_cell #(.IW(IW)) u_cell (
    .clk_i, .rst_ni,
    .vld_i(s3_v_q), .idx_i(s3_i_q), .ok_i(s3_ok_q),
    .d2_i(d2_q), .t2_i(t2_q), .k_i(k_q),
    .vld_o(c_v), .idx_o(c_i), .ok_o(c_ok), .k_o(c_k)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= StepW'(1000);
      steps_q     <= StepsW'(10);
      qry_q       <= '0;
      start_q     <= '0;
      rd_q        <= '0;
      k_q         <= '0;
      tol_q       <= '0;
      max_q       <= '0;
      t2_q        <= '0;
      hit_q       <= 1'b0;
      found_q     <= 1'b0;
      pidx_q      <= '0;
      drain_q     <= '0;
      out_valid_q <= 1'b0;
      res_found_q <= 1'b0;
      res_idx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgStep) step_q <= cfg_data_i;
        else steps_q <= cfg_data_i[StepsW-1:0];
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            unique case (mode_i)
              ModeClear:  count_q <= '0;
              ModeAppend: if (count_q < CW'(MaxPoints)) count_q <= count_q + 1'b1;
              ModeQuery: begin
                qry_q   <= '{lat: latitude_i, lon: longitude_i, hdg: heading_i};
                start_q <= start_index_i;
                pidx_q  <= start_index_i;
                rd_q    <= RW'(start_index_i);
                k_q     <= StepsW'(1);
                tol_q   <= TolW'(step_q);
                t2_q    <= SqW'(step_q) * SqW'(step_q);
                max_q   <= TolW'(step_q) * TolW'(steps_q);
                hit_q   <= 1'b0;
                found_q <= 1'b0;
                state_q <= (steps_q == '0) ? S_DONE : S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          rd_q <= rd_q + 1'b1;
          if (rd_q >= cnt_ext) begin
            state_q <= S_DRAIN;
            drain_q <= '0;
          end
        end
        S_DRAIN: begin
          drain_q <= drain_q + 1'b1;
          if (drain_q == 4'd6) begin
            if (hit_q || k_q == steps_q) begin
              found_q <= hit_q;
              state_q <= S_DONE;
            end else begin
              // Next round: widen tolerance and rescan from the start. The
              // pipeline is empty here, so the new bound cannot reach an
              // entry of the round that just ended.
              k_q   <= k_q + 1'b1;
              tol_q <= tol_q + TolW'(step_q);
              t2_q  <= SqW'(tol_q + TolW'(step_q)) * SqW'(tol_q + TolW'(step_q));
              rd_q  <= RW'(start_q);
              state_q <= S_SCAN;
            end
          end
        end
        S_DONE: if (res_load) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
      // First hit of a round is the earliest index since the scan is in order.
      if (c_v && c_ok && !hit_q && c_k == k_q) begin
        hit_q  <= 1'b1;
        pidx_q <= c_i[IdxW-1:0];
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
        res_found_q <= found_q;
        res_idx_q   <= pidx_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !s0_v_q && !c_v) else $error("scan active while idle");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(point_index_o)
    && $stable(found_o))
    else $error("result changed while stalled");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxPoints))
    else $error("point count past table size");
`endif

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// Route nearest point search testbench
// Appends, clears and queries go in through the input handshake. A scoreboard
// keeps its own point table and predicts each query answer. The tolerance
// settings change between phases, and the two sides idle at varying rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import rnps_pkg::*;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int unsigned WatchdogLimit = 1000000;
  localparam int unsigned TablePoints = MaxPointsDefault;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] idx;
  } search_result_t;

  // Reference copy of the point table plus the queue of pending answers.
  class route_scoreboard;
    longint            lat_tbl[TablePoints];
    longint            lon_tbl[TablePoints];
    logic [HdgW-1:0]   hdg_tbl[TablePoints];
    int unsigned       count;
    longint            tol_step;
    longint            tol_steps;
    search_result_t    answers[$];
    int unsigned       errors;

    function new();
      count = 0;
      tol_step = 1000;
      tol_steps = 10;
      errors = 0;
    endfunction

    function void set_cfg(logic idx, logic [StepW-1:0] val);
      if (idx == CfgStep) tol_step = longint'(val);
      else tol_steps = longint'(val[StepsW-1:0]);
    endfunction

    // Smallest tolerance round in which point i matches, 0 if none.
    function longint match_round(int unsigned i, longint lat, longint lon,
                                 logic [HdgW-1:0] hdg);
      longint maxtol, dl, dn, d2, t;
      maxtol = tol_step * tol_steps;
      if (hdg_tbl[i] != hdg) return 0;
      dl = lat_tbl[i] - lat;
      dn = lon_tbl[i] - lon;
      if (dl < 0) dl = -dl;
      if (dn < 0) dn = -dn;
      if (dl >= maxtol || dn >= maxtol) return 0;
      d2 = dl * dl + dn * dn;
      for (longint k = 1; k <= tol_steps; k++) begin
        t = k * tol_step;
        if (d2 < t * t) return k;
      end
      return 0;
    endfunction

    function void note_item(logic [1:0] mode, longint lat, longint lon,
                            logic [HdgW-1:0] hdg, logic [IdxW-1:0] start);
      search_result_t res;
      longint best, r;
      case (mode)
        ModeClear: count = 0;
        ModeAppend: begin
          if (count < TablePoints) begin
            lat_tbl[count] = lat;
            lon_tbl[count] = lon;
            hdg_tbl[count] = hdg;
            count++;
          end
        end
        ModeQuery: begin
          best = 0;
          res.idx = start;
          for (int unsigned i = start; i < count; i++) begin
            r = match_round(i, lat, lon, hdg);
            if (r != 0 && (best == 0 || r < best)) begin
              best = r;
              res.idx = IdxW'(i);
            end
          end
          res.found = (best != 0);
          answers.insert(answers.size(), res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic found, logic [IdxW-1:0] idx);
      search_result_t exp_res;
      if (answers.size() == 0) begin
        $display("%0t: unexpected result found=%0d index=%0d", $time, found, idx);
        errors++;
        return;
      end
      exp_res = answers.pop_front();
      if (found !== exp_res.found) begin
        $display("%0t: found expected %0d actual %0d", $time, exp_res.found, found);
        errors++;
      end
      if (idx !== exp_res.idx) begin
        $display("%0t: point_index expected %0d actual %0d", $time, exp_res.idx, idx);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic                   cfg_index_i;
  logic [StepW-1:0]       cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [1:0]             mode_i;
  logic signed [LatW-1:0] latitude_i;
  logic signed [LonW-1:0] longitude_i;
  logic [HdgW-1:0]        heading_i;
  logic [IdxW-1:0]        start_index_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic                   found_o;
  logic [IdxW-1:0]        point_index_o;

  route_nearest_point_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .latitude_i    (latitude_i),
    .longitude_i   (longitude_i),
    .heading_i     (heading_i),
    .start_index_i (start_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .point_index_o (point_index_o)
  );

  route_scoreboard sb = new();
  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result side: random stalls, checking and the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(found_o, point_index_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
    out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Called right after a rising edge; returns at the edge that accepts the item.
  task automatic send(logic [1:0] mode, longint lat, longint lon,
                      logic [HdgW-1:0] hdg, logic [IdxW-1:0] start);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    latitude_i    <= lat[LatW-1:0];
    longitude_i   <= lon[LonW-1:0];
    heading_i     <= hdg;
    start_index_i <= start;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(mode, longint'(signed'(lat[LatW-1:0])), longint'(signed'(lon[LonW-1:0])),
                 hdg, start);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.answers.size() != 0) @(posedge clk_i);
    // Let a trailing append or clear settle before touching the registers.
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [StepW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.set_cfg(idx, val);
  endtask

  task automatic set_tolerance(logic [StepW-1:0] step, logic [StepW-1:0] steps);
    drain();
    write_cfg(CfgStep, step);
    write_cfg(CfgSteps, steps);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic longint rand_off(longint maxr);
    longint unsigned span;
    span = longint'(2 * maxr + 1);
    return longint'({$urandom, $urandom} % span) - maxr;
  endfunction

  // One burst of random traffic around a fresh cluster center.
  task automatic random_block(int unsigned n_items);
    longint cen_lat, cen_lon, spread, plat, plon;
    logic [HdgW-1:0] h0;
    int unsigned pick, sel;
    cen_lat = rand_off(longint'(1) << 29);
    cen_lon = rand_off(longint'(1) << 30);
    spread = sb.tol_step * sb.tol_steps * 3 / 2 + 2;
    if (spread > (longint'(1) << 24)) spread = longint'(1) << 24;
    h0 = HdgW'($urandom_range(511));
    if ($urandom_range(3) != 0) send(ModeClear, rand_off(1000), rand_off(1000), 0, 0);
    repeat (n_items) begin
      sel = $urandom_range(99);
      if (sel < 40 || sb.count == 0) begin
        send(ModeAppend, cen_lat + rand_off(spread), cen_lon + rand_off(spread),
             HdgW'(h0 + $urandom_range(1)), IdxW'($urandom));
      end else if (sel < 85) begin
        pick = $urandom_range(sb.count - 1);
        plat = sb.lat_tbl[pick] + rand_off(spread / 2 + 1);
        plon = sb.lon_tbl[pick] + rand_off(spread / 2 + 1);
        send(ModeQuery, plat, plon,
             ($urandom_range(4) == 0) ? HdgW'(h0 + $urandom_range(1)) : sb.hdg_tbl[pick],
             IdxW'(($urandom_range(3) == 0) ? $urandom_range(sb.count + 2) : 0));
      end else if (sel < 93) begin
        send(ModeQuery, rand_off(longint'(1) << 30), rand_off(longint'(1) << 31),
             HdgW'($urandom), IdxW'($urandom));
      end else if (sel < 97) begin
        send(ModeUnused, longint'($urandom), longint'($urandom), HdgW'($urandom),
             IdxW'($urandom));
      end else begin
        send(ModeClear, longint'($urandom), longint'($urandom), HdgW'($urandom),
             IdxW'($urandom));
      end
    end
  endtask

  initial begin
    cfg_we_i      = 1'b0;
    cfg_index_i   = CfgStep;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    mode_i        = ModeClear;
    latitude_i    = '0;
    longitude_i   = '0;
    heading_i     = '0;
    start_index_i = '0;
    rst_ni        = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extremes, round ordering, start past count.
    send(ModeQuery, 0, 0, 0, 0);
    send(ModeAppend, -(longint'(1) << 30), -(longint'(1) << 31), 0, 0);
    send(ModeAppend, (longint'(1) << 30) - 1, (longint'(1) << 31) - 1, 359, 1023);
    send(ModeAppend, 0, 0, 511, 0);
    send(ModeAppend, 0, 2500, 100, 0);
    send(ModeAppend, 0, 700, 100, 0);
    send(ModeAppend, 500, 0, 100, 0);
    send(ModeQuery, -(longint'(1) << 30), -(longint'(1) << 31), 0, 0);
    send(ModeQuery, (longint'(1) << 30) - 1, (longint'(1) << 31) - 1, 359, 0);
    send(ModeQuery, 0, 0, 511, 0);
    send(ModeQuery, 0, 0, 100, 0);
    send(ModeQuery, 0, 9999, 100, 0);
    send(ModeQuery, 0, 10000, 100, 0);
    send(ModeQuery, 0, 2000, 100, 4);
    send(ModeQuery, 0, 0, 100, 6);
    send(ModeQuery, 0, 0, 100, 1023);
    send(ModeQuery, 0, 0, 101, 0);
    send(ModeUnused, 0, 0, 100, 0);
    send(ModeClear, 0, 0, 0, 0);
    send(ModeQuery, 0, 0, 100, 0);
    drain();

    for (int blk = 0; blk < 20; blk++) begin
      case (blk % 4)
        0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_gap_pct = 61; rx_stall_pct = 0;  end
        2: begin tx_gap_pct = 0;  rx_stall_pct = 61; end
        default: begin tx_gap_pct = 33; rx_stall_pct = 33; end
      endcase
      case (blk)
        2:  set_tolerance(1, 1);
        4:  set_tolerance(100000, 64);
        6:  set_tolerance(1, 64);
        8:  set_tolerance(100000, 1);
        10: set_tolerance(0, 10);
        11: set_tolerance(500, 0);
        12: set_tolerance(131071, 127);
        14: set_tolerance($urandom_range(1, 100000), $urandom_range(1, 64));
        16: set_tolerance(1000, 10);
        18: set_tolerance($urandom_range(1, 5000), $urandom_range(1, 20));
        default: ;
      endcase
      random_block(27);
      if (blk == 9) drain();
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[route_nearest_point_search.f]
hdl/rnps_pkg.sv
hdl/rnps_cell.sv
hdl/route_nearest_point_search.sv
verif/tb_top.sv
